>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int Depth  = 16;
  localparam int ValueW = 32;
  localparam int CountW = $clog2(Depth + 1);
  localparam int CapW   = 5;

  localparam logic [CapW-1:0] CapacityReset = CapW'(16);

  localparam logic ModeEnqueue = 1'b0;
  localparam logic ModeDequeue = 1'b1;

  localparam logic [1:0] StInserted = 2'd0;
  localparam logic [1:0] StRemoved  = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              deq;
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/sorted_priority_queue.sv
// Minimum priority queue held in a row of 16 compare-and-shift cells kept in
// ascending order; equal values leave in arrival order. Every cell compares
// its entry with the new value in parallel and shifts in the same clock, so an
// item can be accepted every cycle while in_stall_o is low and its result
// appears in the output register on the next cycle. in_stall_o only rises
// while a finished result is held by out_stall_i. The capacity register is
// written through cfg_valid_i/cfg_ready_o, always ready, and its value is
// saturated to the 16 cells of the row; write it only while the queue has no
// result pending.
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic signed [spq_pkg::ValueW-1:0] value_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [spq_pkg::ValueW-1:0] value_out_o,
  output logic [1:0]                    status_o,
  output logic [spq_pkg::CountW-1:0]    count_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spq_pkg::CapW-1:0]      cfg_capacity_i
);
  import spq_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [CapW-1:0]   capacity_q;
  logic              out_valid_q;
  logic [ValueW-1:0] value_out_q, value_out_d;
  logic [1:0]        status_q, status_d;
  logic [CountW-1:0] count_out_q;

  logic       accept, full, empty;
  int         cap_eff;
  cell_ctrl_t ctrl;

  logic [Depth-1:0]             occ;
  logic [Depth-1:0]             take;
  logic [Depth-1:0][ValueW-1:0] cell_value;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  assign cap_eff = (int'(capacity_q) > Depth) ? Depth : int'(capacity_q);
  assign full    = int'(count_q) >= cap_eff;
  assign empty   = (count_q == '0);

  assign ctrl.ins   = accept && (mode_i == ModeEnqueue) && !full;
  assign ctrl.deq   = accept && (mode_i == ModeDequeue) && !empty;
  assign ctrl.value = value_in_i;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic              left_take;
    logic [ValueW-1:0] left_value, right_value;

    assign occ[i] = count_q > CountW'(i);

    if (i == 0) begin : g_first
      assign left_take  = 1'b0;
      assign left_value = ctrl.value;
    end else begin : g_mid
      assign left_take  = take[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .left_take_i   (left_take),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .take_o        (take[i]),
      .value_o       (cell_value[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    value_out_d = '0;
    if (mode_i == ModeEnqueue) begin
      if (full) begin
        status_d = StFull;
      end else begin
        status_d = StInserted;
        count_d  = count_q + CountW'(1);
      end
    end else begin
      if (empty) begin
        status_d = StEmpty;
      end else begin
        status_d    = StRemoved;
        value_out_d = cell_value[0];
        count_d     = count_q - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      capacity_q  <= CapacityReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_capacity_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_out_q <= value_out_d;
      status_q    <= status_d;
      count_out_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;
  assign count_out_o = count_out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= Depth)
    else $error("stored count beyond the cell row");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (count_q == $past(count_q) + CountW'(1)) && (status_q == StInserted))
    else $error("insert did not grow the count");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.deq |=> (count_out_q == $past(count_q) - CountW'(1)) && (status_q == StRemoved))
    else $error("remove did not shrink the count");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == StEmpty || status_q == StFull) |-> value_out_q == '0)
    else $error("refused item carries a value");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item gave no result");
`endif

endmodule

>>> hw/rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic                           clk_i,
  input  spq_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           occ_i,
  input  logic                           left_take_i,
  input  logic [spq_pkg::ValueW-1:0]     left_value_i,
  input  logic [spq_pkg::ValueW-1:0]     right_value_i,
  output logic                           take_o,
  output logic [spq_pkg::ValueW-1:0]     value_o
);
  import spq_pkg::*;

  logic [ValueW-1:0] value_q, value_d;
  logic              gt;

  // the new item lands at or before this cell
  assign gt     = occ_i && ($signed(value_q) > $signed(ctrl_i.value));
  assign take_o = gt || !occ_i;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (left_take_i) begin
        value_d = left_value_i;
      end else if (take_o) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.deq) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> test/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CycleLimit = 400_000;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [1:0]               status;
    logic [CountW-1:0]        count;
  } qresult_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     mode_i;
  logic signed [ValueW-1:0] value_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [ValueW-1:0] value_out_o;
  logic [1:0]               status_o;
  logic [CountW-1:0]        count_out_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CapW-1:0]          cfg_capacity_i;

  // shadow copy of the queue contents and the capacity register
  logic signed [ValueW-1:0] shadow_vals[Depth];
  int                       shadow_count;
  int                       shadow_cap;

  qresult_t awaited_results[$];
  int       error_count;
  int       cycle_count;
  bit       idle_on;
  int       stall_left;

  sorted_priority_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .value_in_i     (value_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_out_o    (value_out_o),
    .status_o       (status_o),
    .count_out_o    (count_out_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      1: return 32'h7fff_ffff - 32'($urandom_range(0, 3));
      2: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic qresult_t predict_queue_op(logic op, logic signed [ValueW-1:0] v);
    qresult_t r;
    int       i;
    int       eff_cap;
    eff_cap = (shadow_cap > Depth) ? Depth : shadow_cap;
    r.value = '0;
    if (op == ModeEnqueue) begin
      if (shadow_count >= eff_cap) begin
        r.status = StFull;
      end else begin
        // new value goes after every stored value not greater than it
        i = shadow_count;
        while (i > 0 && shadow_vals[i-1] > v) begin
          shadow_vals[i] = shadow_vals[i-1];
          i--;
        end
        shadow_vals[i] = v;
        shadow_count++;
        r.status = StInserted;
      end
    end else if (shadow_count == 0) begin
      r.status = StEmpty;
    end else begin
      r.value = shadow_vals[0];
      for (i = 1; i < shadow_count; i++) shadow_vals[i-1] = shadow_vals[i];
      shadow_count--;
      r.status = StRemoved;
    end
    r.count = CountW'(shadow_count);
    return r;
  endfunction

  // output side stall, alternating stalled and free runs
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall_i || !idle_on) begin
      out_stall_i <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
    end
  end

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    qresult_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual value %0d status %0d count %0d",
                 $time, value_out_o, status_o, count_out_o);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("value_out", want.value, value_out_o);
        compare_field("status", want.status, status_o);
        compare_field("count_out", want.count, count_out_o);
      end
    end
  end

  // called just after a falling edge; leaves valid high on return
  task automatic issue_op(logic op, logic signed [ValueW-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= op;
    value_in_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(predict_queue_op(op, v));
    @(negedge clk_i);
  endtask

  task automatic wait_queue_idle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] cap);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_cap = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_dequeue();
    issue_op(ModeDequeue, $urandom);
    issue_op(ModeDequeue, 32'h8000_0000);
    wait_queue_idle();
  endtask

  task automatic test_value_ordering();
    issue_op(ModeEnqueue, 32'h7fff_ffff);
    issue_op(ModeEnqueue, 32'h8000_0000);
    issue_op(ModeEnqueue, 32'sd0);
    issue_op(ModeEnqueue, -32'sd1);
    issue_op(ModeEnqueue, 32'sd1);
    issue_op(ModeEnqueue, 32'sd0);
    repeat (6) issue_op(ModeDequeue, $urandom);
    issue_op(ModeDequeue, 32'hffff_ffff);
    wait_queue_idle();
  endtask

  task automatic test_capacity_limits();
    write_capacity(CapW'(2));
    issue_op(ModeEnqueue, 32'sd5);
    issue_op(ModeEnqueue, 32'sd5);
    issue_op(ModeEnqueue, -32'sd7);
    wait_queue_idle();
    // lowered below the stored count: refuse until drained under it
    write_capacity(CapW'(1));
    issue_op(ModeEnqueue, 32'sd3);
    issue_op(ModeDequeue, 32'sd0);
    issue_op(ModeEnqueue, 32'sd3);
    issue_op(ModeDequeue, 32'sd0);
    issue_op(ModeEnqueue, 32'h8000_0000);
    wait_queue_idle();
    write_capacity(CapW'(0));
    issue_op(ModeDequeue, 32'sd0);
    issue_op(ModeEnqueue, 32'sd9);
    issue_op(ModeDequeue, 32'sd0);
    wait_queue_idle();
  endtask

  task automatic test_random_traffic(logic [CapW-1:0] cap, int n_items, int enq_pct);
    int k;
    write_capacity(cap);
    for (k = 0; k < n_items; k++) begin
      // stretches with no idling on either side
      if (k % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < enq_pct) issue_op(ModeEnqueue, rand_value());
      else issue_op(ModeDequeue, $urandom);
    end
    wait_queue_idle();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = ModeEnqueue;
    value_in_i     = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_capacity_i = CapacityReset;
    shadow_count   = 0;
    shadow_cap     = CapacityReset;
    error_count    = 0;
    cycle_count    = 0;
    stall_left     = 0;
    idle_on        = 1'b1;
    foreach (shadow_vals[i]) shadow_vals[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_dequeue();
    test_value_ordering();
    test_capacity_limits();
    test_random_traffic(CapW'(16), 250, 65);
    test_random_traffic(CapW'(31), 200, 55);
    test_random_traffic(CapW'(5), 150, 50);
    test_random_traffic(CapW'(1), 100, 50);
    test_random_traffic(CapW'(12), 200, 45);
    test_random_traffic(CapW'(16), 200, 35);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
